[design/tcc_pkg.sv]
// Shared types, constants and helper functions for the congestion control engine.
`timescale 1ns / 1ps
package tcc_pkg;

    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int RING_CW    = $clog2(RING_DEPTH + 1);
    localparam int BURST_MAX  = 64;
    localparam int BURST_CW   = $clog2(BURST_MAX + 1);

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_RETX = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_STAT = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SS   = 2'd1;
    localparam logic [1:0] PH_CA   = 2'd2;
    localparam logic [1:0] PH_FR   = 2'd3;

    localparam logic [2:0] REG_MSS     = 3'd0;
    localparam logic [2:0] REG_PAYLOAD = 3'd1;
    localparam logic [2:0] REG_STEP    = 3'd2;
    localparam logic [2:0] REG_FILELEN = 3'd3;
    localparam logic [2:0] REG_TOMULT  = 3'd4;
    localparam logic [2:0] REG_SSTHR   = 3'd5;

    localparam logic [39:0] RTT_RESET = 40'd1000000;

    typedef struct packed {
        logic        command;
        logic [31:0] ack_seq;
        logic [39:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq_begin;
        logic [31:0] seq_end;
        logic [31:0] payload_offset;
        logic [10:0] payload_length;
        logic [1:0]  phase;
        logic [31:0] window_bytes;
        logic [31:0] threshold_bytes;
        logic [31:0] outstanding_bytes;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } t_div_rsp;

    function automatic logic [31:0] offset_of(input logic [31:0] seq);
        return (seq == 32'd1) ? 32'd0 : seq - 32'd2;
    endfunction

    function automatic logic [10:0] bytes_at(input logic [31:0] seq,
                                             input logic [31:0] flen,
                                             input logic [10:0] pbytes);
        logic [31:0] off;
        logic [31:0] remain;
        off    = offset_of(seq);
        remain = flen - off;
        if (off >= flen) return 11'd0;
        if (remain < {21'd0, pbytes}) return remain[10:0];
        return pbytes;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[design/tcc_if.sv]
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface tcc_in_if;
    logic               valid;
    logic               ready;
    tcc_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tcc_out_if;
    logic               valid;
    logic               ready;
    tcc_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/tcc_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tcc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcc_pkg::t_div_req i_req,
    output tcc_pkg::t_div_rsp o_rsp
);
    import tcc_pkg::*;

    logic [31:0] r_rem, r_quo, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] sh;
    logic [32:0] diff;
    logic        qbit;

    assign sh   = {r_rem, r_quo[31]};
    assign diff = sh - {1'b0, r_den};
    assign qbit = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract when it fits
                r_rem <= qbit ? diff[31:0] : sh[31:0];
                r_quo <= {r_quo[30:0], qbit};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

[design/tcp_congestion_control_engine_top.sv]
// Top level of the Reno-style congestion control engine.
`timescale 1ns / 1ps
// The engine takes one item (ACK or timer tick) at a time and is not ready
// until every result of that item has been transferred. A sequencer drives
// a shared divider (window growth in congestion avoidance and the rounding
// of ssthresh), walks the send timestamp ring one entry at a time when an
// ACK releases entries, pushes one new segment per cycle in a burst, and
// then replays the burst from the ring, one result at a time, each held
// until the output takes it. All results of one item carry the state at the
// end of that item. Register writes must go through the APB port only while
// the engine is idle; the block itself does not enforce this. pready is tied
// high and reads return the register value.
module tcp_congestion_control_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcc_in_if.sink      i_item,
    tcc_out_if.source   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcc_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_TICK_RD  = 4'd2;
    localparam logic [3:0] S_TICK_CMP = 4'd3;
    localparam logic [3:0] S_REL_RD   = 4'd4;
    localparam logic [3:0] S_REL_CHK  = 4'd5;
    localparam logic [3:0] S_CONT     = 4'd6;
    localparam logic [3:0] S_DIVW     = 4'd7;
    localparam logic [3:0] S_CUT      = 4'd8;
    localparam logic [3:0] S_CUTDIV   = 4'd9;
    localparam logic [3:0] S_CUTFIN   = 4'd10;
    localparam logic [3:0] S_BURST    = 4'd11;
    localparam logic [3:0] S_OUT_RD   = 4'd12;
    localparam logic [3:0] S_OUT_LD   = 4'd13;
    localparam logic [3:0] S_OUT_WAIT = 4'd14;

    // configuration
    logic [15:0] r_mss, r_ssthr;
    logic [10:0] r_pbytes, r_step;
    logic [31:0] r_flen;
    logic [3:0]  r_tomult;

    // connection state
    logic [3:0]  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_window, n_window, r_thresh, n_thresh;
    logic [31:0] r_acked, n_acked, r_sent_end, n_sent_end, r_outst, n_outst;
    logic [7:0]  r_dup, n_dup;
    logic [39:0] r_rtt, n_rtt, r_first, n_first;
    logic [1:0]  r_rflags, n_rflags, r_done, n_done;
    logic [RING_AW-1:0] r_head, n_head, r_tail, n_tail, r_start, n_start;
    logic [RING_CW-1:0] r_count, n_count;

    // item and step bookkeeping
    logic        r_cmd;
    logic [31:0] r_seq;
    logic [39:0] r_now;
    logic        r_recov, n_recov;
    logic [1:0]  r_mode, n_mode;
    logic [BURST_CW-1:0] r_sent, n_sent, r_k, n_k;
    logic [31:0] r_ss, n_ss;
    logic [43:0] r_limit;

    // result register
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_okind, n_okind;
    logic [31:0] r_obeg, n_obeg, r_oend, n_oend, r_ooff, n_ooff;
    logic [10:0] r_olen, n_olen;
    logic        r_olast, n_olast;

    // timestamp ring
    logic [31:0] ring_seq  [RING_DEPTH];
    logic [39:0] ring_time [RING_DEPTH];
    logic [RING_AW-1:0] rd_addr;
    logic [31:0] r_rd_seq;
    logic [39:0] r_rd_time;
    logic        ring_we;
    logic [31:0] push_seq;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic        accept, cfg_wr;
    logic [31:0] b_seq, b_end;
    logic [10:0] b_len;
    logic [31:0] o_seg;
    logic [10:0] o_len;
    logic [32:0] floor2;
    logic [31:0] ss_raw;
    logic [39:0] age;

    tcc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign cfg_wr       = psel && penable && pwrite;
    assign pready       = 1'b1;

    always_comb begin
        unique case (paddr[4:2])
            REG_MSS:     prdata = {16'd0, r_mss};
            REG_PAYLOAD: prdata = {21'd0, r_pbytes};
            REG_STEP:    prdata = {21'd0, r_step};
            REG_FILELEN: prdata = r_flen;
            REG_TOMULT:  prdata = {28'd0, r_tomult};
            REG_SSTHR:   prdata = {16'd0, r_ssthr};
            default:     prdata = 32'd0;
        endcase
    end

    // next segment of a burst
    assign b_seq    = r_sent_end + 32'd1;
    assign b_len    = bytes_at(b_seq, r_flen, r_pbytes);
    assign b_end    = b_seq + {21'd0, b_len};
    assign push_seq = b_seq;

    // result fields: data segments replay from the ring, a retransmit starts at acked
    assign o_seg = (r_mode == KIND_DATA) ? r_rd_seq : r_acked;
    assign o_len = bytes_at(o_seg, r_flen, r_pbytes);

    assign floor2 = {16'd0, r_mss, 1'b0};
    assign ss_raw = ({1'b0, r_window >> 1} < floor2) ? floor2[31:0] : (r_window >> 1);
    assign age    = r_now - r_rd_time;

    always_comb begin
        n_state = r_state;   n_phase = r_phase;   n_window = r_window;
        n_thresh = r_thresh; n_acked = r_acked;   n_sent_end = r_sent_end;
        n_outst = r_outst;   n_dup = r_dup;       n_rtt = r_rtt;
        n_first = r_first;   n_rflags = r_rflags; n_done = r_done;
        n_head = r_head;     n_tail = r_tail;     n_count = r_count;
        n_start = r_start;   n_recov = r_recov;   n_mode = r_mode;
        n_sent = r_sent;     n_k = r_k;           n_ss = r_ss;
        n_ovalid = r_ovalid; n_okind = r_okind;   n_obeg = r_obeg;
        n_oend = r_oend;     n_ooff = r_ooff;     n_olen = r_olen;
        n_olast = r_olast;
        div_req = '0;
        rd_addr = r_tail;
        ring_we = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DEC;
            end
            S_DEC: begin
                n_sent  = '0;
                n_start = r_head;
                n_k     = '0;
                if (!r_cmd && r_seq == 32'd1) begin
                    // open or restart: clear the connection, then grow and send
                    n_acked = 32'd1;     n_sent_end = '0; n_outst = '0;
                    n_dup = '0;          n_rtt = RTT_RESET;
                    n_first = r_now;     n_rflags = 2'b01; n_done = '0;
                    n_head = '0;         n_tail = '0;      n_count = '0;
                    n_start = '0;
                    n_thresh = {16'd0, r_ssthr};
                    n_window = {21'd0, r_step};
                    n_phase  = ({5'd0, r_step} >= r_ssthr) ? PH_CA : PH_SS;
                    n_state  = S_BURST;
                end else if (r_phase == PH_IDLE || r_done[1]) begin
                    n_mode  = KIND_STAT;
                    n_state = S_OUT_RD;
                end else if (r_cmd) begin
                    n_state = (r_count != '0) ? S_TICK_RD : S_BURST;
                end else if (r_seq == r_acked && r_phase != PH_FR) begin
                    n_dup = r_dup + 8'd1;
                    if (r_dup + 8'd1 == 8'd3) begin
                        n_recov = 1'b1;
                        n_state = S_CUT;
                    end else begin
                        n_state = S_CONT;
                    end
                end else if (r_seq == r_acked) begin
                    n_state = S_CONT;
                end else begin
                    // new ACK: probe RTT in slow start, retire bytes, release ring
                    if (r_phase == PH_SS && !r_rflags[1]) begin
                        if (!r_rflags[0]) begin
                            n_first  = r_now;
                            n_rflags = r_rflags | 2'b01;
                        end else begin
                            n_rtt    = r_now - r_first;
                            n_rflags = r_rflags | 2'b10;
                        end
                    end
                    n_outst = r_outst - (r_seq - r_acked);
                    n_state = S_REL_RD;
                end
            end
            S_TICK_RD: begin
                rd_addr = r_tail;
                n_state = S_TICK_CMP;
            end
            S_TICK_CMP: begin
                if ({4'd0, age} > r_limit) begin
                    n_recov = 1'b0;
                    n_state = S_CUT;
                end else begin
                    n_state = S_BURST;
                end
            end
            S_REL_RD: begin
                rd_addr = r_tail;
                n_state = S_REL_CHK;
            end
            S_REL_CHK: begin
                if (r_count != '0 && r_rd_seq <= r_seq) begin
                    n_tail  = r_tail + 1'b1;
                    n_count = r_count - 1'b1;
                    n_state = S_REL_RD;
                end else if (r_done[0] && r_outst == 32'd0) begin
                    n_done  = r_done | 2'b10;
                    n_mode  = KIND_END;
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_CONT;
                end
            end
            S_CONT: begin
                unique case (r_phase)
                    PH_SS: begin
                        n_acked  = r_seq;
                        n_window = sat_add(r_window, {21'd0, r_step});
                        n_phase  = (n_window >= r_thresh) ? PH_CA : PH_SS;
                        n_state  = S_BURST;
                    end
                    PH_CA: begin
                        n_acked          = r_seq;
                        div_req.start    = 1'b1;
                        div_req.dividend = {16'd0, r_mss} * {16'd0, r_mss};
                        div_req.divisor  = (r_window == 32'd0) ? 32'd1 : r_window;
                        n_state          = S_DIVW;
                    end
                    default: begin
                        if (r_seq != r_acked) begin
                            n_acked = r_seq;
                            n_phase = PH_CA;
                            if (r_thresh == {16'd0, r_ssthr}) n_thresh = r_window;
                        end else begin
                            n_window = sat_add(r_window, {21'd0, r_step});
                        end
                        n_state = S_BURST;
                    end
                endcase
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    n_window = sat_add(r_window, div_rsp.quo);
                    n_state  = S_BURST;
                end
            end
            S_CUT: begin
                n_ss = ss_raw;
                if (r_mss != 16'd0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = ss_raw;
                    div_req.divisor  = {16'd0, r_mss};
                    n_state          = S_CUTDIV;
                end else begin
                    n_thresh = ss_raw;
                    n_state  = S_CUTFIN;
                end
            end
            S_CUTDIV: begin
                if (div_rsp.done) begin
                    n_thresh = r_ss - div_rsp.rem;
                    n_state  = S_CUTFIN;
                end
            end
            S_CUTFIN: begin
                if (r_recov) begin
                    n_phase  = PH_FR;
                    n_window = sat_add(r_thresh, {14'd0, r_mss, 2'd0} - {16'd0, r_mss});
                end else begin
                    n_phase  = PH_SS;
                    n_window = {16'd0, r_mss};
                end
                n_dup   = '0;
                n_mode  = KIND_RETX;
                n_state = S_OUT_RD;
            end
            S_BURST: begin
                if (r_outst < r_window && r_sent < BURST_CW'(BURST_MAX) &&
                    r_count < RING_CW'(RING_DEPTH)) begin
                    if (b_len == 11'd0) begin
                        n_done  = r_done | 2'b01;
                        n_mode  = (r_sent == '0) ? KIND_STAT : KIND_DATA;
                        n_state = S_OUT_RD;
                    end else begin
                        ring_we    = 1'b1;
                        n_sent_end = b_end;
                        n_outst    = b_end - r_acked + 32'd1;
                        n_head     = r_head + 1'b1;
                        n_count    = r_count + 1'b1;
                        n_sent     = r_sent + 1'b1;
                    end
                end else begin
                    n_mode  = (r_sent == '0) ? KIND_STAT : KIND_DATA;
                    n_state = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                rd_addr = r_start + r_k[RING_AW-1:0];
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_ovalid = 1'b1;
                n_okind  = r_mode;
                n_olast  = (r_mode != KIND_DATA) || (r_k == r_sent - 1'b1);
                if (r_mode == KIND_DATA || r_mode == KIND_RETX) begin
                    n_obeg = o_seg;
                    n_oend = o_seg + {21'd0, o_len};
                    n_ooff = offset_of(o_seg);
                    n_olen = o_len;
                end else begin
                    n_obeg = '0; n_oend = '0; n_ooff = '0; n_olen = '0;
                end
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (o_result.ready) begin
                    n_ovalid = 1'b0;
                    n_k      = r_k + 1'b1;
                    n_state  = r_olast ? S_IDLE : S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss <= 16'd100;   r_pbytes <= 11'd36; r_step <= 11'd44;
            r_flen <= '0;       r_tomult <= 4'd6;   r_ssthr <= 16'd65535;
            r_state <= S_IDLE;  r_phase <= PH_IDLE; r_window <= '0;
            r_thresh <= 32'd65535;
            r_acked <= '0;      r_sent_end <= '0;   r_outst <= '0;
            r_dup <= '0;        r_rtt <= RTT_RESET; r_first <= '0;
            r_rflags <= '0;     r_done <= '0;
            r_head <= '0;       r_tail <= '0;       r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_MSS:     r_mss    <= pwdata[15:0];
                    REG_PAYLOAD: r_pbytes <= pwdata[10:0];
                    REG_STEP:    r_step   <= pwdata[10:0];
                    REG_FILELEN: r_flen   <= pwdata;
                    REG_TOMULT:  r_tomult <= pwdata[3:0];
                    REG_SSTHR:   r_ssthr  <= pwdata[15:0];
                    default: ;
                endcase
            end
            r_state <= n_state;   r_phase <= n_phase;   r_window <= n_window;
            r_thresh <= n_thresh; r_acked <= n_acked;   r_sent_end <= n_sent_end;
            r_outst <= n_outst;   r_dup <= n_dup;       r_rtt <= n_rtt;
            r_first <= n_first;   r_rflags <= n_rflags; r_done <= n_done;
            r_head <= n_head;     r_tail <= n_tail;     r_count <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // payload and bookkeeping registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_item.payload.command;
            r_seq <= i_item.payload.ack_seq;
            r_now <= i_item.payload.now_us;
        end
        r_start <= n_start; r_recov <= n_recov; r_mode <= n_mode;
        r_sent <= n_sent;   r_k <= n_k;         r_ss <= n_ss;
        r_okind <= n_okind; r_obeg <= n_obeg;   r_oend <= n_oend;
        r_ooff <= n_ooff;   r_olen <= n_olen;   r_olast <= n_olast;
        r_limit <= {40'd0, r_tomult} * {4'd0, r_rtt};
    end

    // timestamp ring: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_seq[r_head]  <= push_seq;
            ring_time[r_head] <= r_now;
        end
        r_rd_seq  <= ring_seq[rd_addr];
        r_rd_time <= ring_time[rd_addr];
    end

    assign o_result.valid                     = r_ovalid;
    assign o_result.payload.kind              = r_okind;
    assign o_result.payload.seq_begin         = r_obeg;
    assign o_result.payload.seq_end           = r_oend;
    assign o_result.payload.payload_offset    = r_ooff;
    assign o_result.payload.payload_length    = r_olen;
    assign o_result.payload.phase             = r_phase;
    assign o_result.payload.window_bytes      = r_window;
    assign o_result.payload.threshold_bytes   = r_thresh;
    assign o_result.payload.outstanding_bytes = r_outst;
    assign o_result.payload.last              = r_olast;

`ifndef SYNTH
    // a result is shown only while the sequencer waits on the output
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == S_OUT_WAIT))
        else $error("result valid outside output wait");

    // the ring never holds more entries than it has room for
    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RING_CW'(RING_DEPTH))
        else $error("ring count overflow");

    // no new item while a result is still pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !i_item.ready)
        else $error("input ready while result pending");
`endif
endmodule
